### rtl/fpaf_pkg.sv
// shared constants, types and divide-by-ten helpers for the fixed-point ascii formatter
`default_nettype none
package fpaf_pkg;

   localparam int DEFAULT_FRACTION_BITS = 8;
   localparam int STAGES = 7;
   localparam int RAW_W = 32;
   localparam int CHARS = 6;
   localparam int SCALED_W = 20;
   localparam int HUND_W = 17;
   localparam int SCALE_W = 10;

   localparam int SIGNED_LIMIT = 9999;
   localparam int SCALE_X1000 = 1000;
   localparam logic [HUND_W-1:0] HUND_OVERFLOW = 17'd100000;
   localparam logic [HUND_W-1:0] HUND_THOU = 17'd1000;
   localparam logic [HUND_W-1:0] HUND_TTHOU = 17'd10000;

   // ceil(2^23 / 10), exact quotient for any operand below 2^22
   localparam logic [SCALED_W-1:0] DIV10_RECIP = 20'd838861;
   localparam int DIV10_SHIFT = 23;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic MODE_SIGNED = 1'b0;
   localparam logic MODE_UNSIGNED = 1'b1;

   typedef struct packed {
      logic mode;
      logic neg;
      logic oor;
      logic big_thou;
      logic big_tthou;
   } ctl_type;

   function automatic logic [SCALED_W-1:0] div10(input logic [SCALED_W-1:0] x);
      logic [2*SCALED_W-1:0] prod;
      prod = (2*SCALED_W)'(x) * (2*SCALED_W)'(DIV10_RECIP);
      return {3'b000, prod[2*SCALED_W-1:DIV10_SHIFT]};
   endfunction

   function automatic logic [3:0] rem10(input logic [SCALED_W-1:0] x,
                                        input logic [SCALED_W-1:0] q);
      logic [SCALED_W-1:0] t;
      t = x - ((q << 3) + (q << 1));
      return t[3:0];
   endfunction

endpackage
`default_nettype wire

### rtl/fixed_point_ascii_formatter.sv
// top level: pipelined fixed-point to six-character decimal ascii formatter
// one register stage per step, from req item accepted to rsp_tvalid
// throughput: one item per cycle while not stalled; each stage holds on its own so bubbles close up under stall
// the longest stage is a 20 by 20 reciprocal multiply used for every divide by ten
// reset (synchronous, active high) empties the pipeline and sets format_mode to signed
`default_nettype none
module fixed_point_ascii_formatter #(
   parameter int FRACTION_BITS = fpaf_pkg::DEFAULT_FRACTION_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_wdata,    // format_mode
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // raw_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,    // char_0 .. char_5, char_0 lowest
   output logic             rsp_tuser     // out_of_range
);
   import fpaf_pkg::*;

   localparam int LIMIT_RAW = (SCALE_X1000 << FRACTION_BITS) - 1;
   localparam int VAL_W_U = $clog2(SCALE_X1000 << FRACTION_BITS);
   localparam int VAL_W = (VAL_W_U > 14) ? VAL_W_U : 14;
   localparam int PROD_W = VAL_W + SCALE_W;
   localparam logic [RAW_W-1:0] LIMIT = RAW_W'(LIMIT_RAW);

   logic             mode_ff;
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   ctl_type ctl_ff [STAGES-1];
   ctl_type ctl_in [STAGES-1];

   logic [VAL_W-1:0]    s0_val_ff, s0_val_in;
   logic [SCALED_W-1:0] s1_scaled_ff, s1_scaled_in;
   logic [HUND_W-1:0]   s2_hund_ff, s2_hund_in;
   logic [13:0]         s3_quo_ff, s3_quo_in;
   logic [9:0]          s4_quo_ff, s4_quo_in;
   logic [6:0]          s5_quo_ff, s5_quo_in;
   logic [4:0][3:0]     s3_digs_ff, s3_digs_in;
   logic [4:0][3:0]     s4_digs_ff, s4_digs_in;
   logic [4:0][3:0]     s5_digs_ff, s5_digs_in;
   logic [47:0]         out_chars_ff, out_chars_in;
   logic                out_oor_ff, out_oor_in;

   logic [RAW_W-1:0]    mag;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]   shifted;
   logic [SCALED_W-1:0] q2, q3, q4, q5, q6;
   logic [SCALED_W-1:0] hund_sum;
   logic [3:0]          r2, d3, d4;
   logic [4:0][3:0]     digs;
   logic [7:0]          ch [CHARS];

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SIGNED;
      end else if (csr_valid) begin
         mode_ff <= csr_wdata;
      end
   end

   // per-stage flow control
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_in = {vld_ff[STAGES-2:0], req_tvalid};
   assign req_tready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // stage 0: sign, magnitude and range check
   assign mag = req_tdata[31] ? (~req_tdata) + 32'd1 : req_tdata;

   always_comb begin
      s0_val_in = (mode_ff == MODE_UNSIGNED) ? req_tdata[VAL_W-1:0] : mag[VAL_W-1:0];
   end

   // stage 1: scale binary fraction to thousandths in unsigned mode; signed values pass through
   assign prod = PROD_W'(s0_val_ff) * PROD_W'(SCALE_X1000);
   assign shifted = prod >> FRACTION_BITS;
   assign s1_scaled_in = (ctl_ff[0].mode == MODE_UNSIGNED) ? shifted[SCALED_W-1:0]
                                                          : SCALED_W'(s0_val_ff);

   // stage 2: round half-up to hundredths in unsigned mode; signed values pass through
   assign q2 = div10(s1_scaled_ff);
   assign r2 = rem10(s1_scaled_ff, q2);
   assign hund_sum = q2 + {19'b0, (r2 >= 4'd5)};
   assign s2_hund_in = (ctl_ff[1].mode == MODE_UNSIGNED) ? hund_sum[HUND_W-1:0]
                                                        : s1_scaled_ff[HUND_W-1:0];

   // stages 3 to 5: one decimal digit each
   assign q3 = div10({3'b000, s2_hund_ff});
   assign s3_quo_in = q3[13:0];
   assign q4 = div10({6'b0, s3_quo_ff});
   assign s4_quo_in = q4[9:0];
   assign q5 = div10({10'b0, s4_quo_ff});
   assign s5_quo_in = q5[6:0];

   always_comb begin
      s3_digs_in = '0;
      s3_digs_in[0] = rem10({3'b000, s2_hund_ff}, q3);
      s4_digs_in = s3_digs_ff;
      s4_digs_in[1] = rem10({6'b0, s3_quo_ff}, q4);
      s5_digs_in = s4_digs_ff;
      s5_digs_in[2] = rem10({10'b0, s4_quo_ff}, q5);
   end

   // control word of stages 0 to 5
   always_comb begin
      ctl_in[0].mode = mode_ff;
      ctl_in[0].neg = req_tdata[31];
      ctl_in[0].oor = (mode_ff == MODE_UNSIGNED) ? (req_tdata > LIMIT)
                                                 : (mag > RAW_W'(SIGNED_LIMIT));
      ctl_in[0].big_thou = 1'b0;
      ctl_in[0].big_tthou = 1'b0;
      for (int k = 1; k < STAGES - 1; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end
      ctl_in[2].oor = ctl_ff[1].oor ||
                      ((ctl_ff[1].mode == MODE_UNSIGNED) && (s2_hund_in == HUND_OVERFLOW));
      ctl_in[3].big_thou = (s2_hund_ff >= HUND_THOU);
      ctl_in[3].big_tthou = (s2_hund_ff >= HUND_TTHOU);
   end

   // stage 6: last two digits and character assembly
   assign q6 = div10({13'b0, s5_quo_ff});
   assign d3 = rem10({13'b0, s5_quo_ff}, q6);
   assign d4 = q6[3:0];

   always_comb begin
      digs = s5_digs_ff;
      digs[3] = d3;
      digs[4] = d4;
      if (ctl_ff[5].mode == MODE_SIGNED) begin
         if (ctl_ff[5].oor) begin
            ch[0] = CHAR_SPACE;
            ch[1] = CHAR_STAR;
            ch[2] = CHAR_DOT;
            ch[3] = CHAR_STAR;
            ch[4] = CHAR_STAR;
            ch[5] = CHAR_STAR;
         end else begin
            ch[0] = ctl_ff[5].neg ? CHAR_MINUS : CHAR_SPACE;
            ch[1] = ASCII_ZERO + {4'b0, digs[3]};
            ch[2] = CHAR_DOT;
            ch[3] = ASCII_ZERO + {4'b0, digs[2]};
            ch[4] = ASCII_ZERO + {4'b0, digs[1]};
            ch[5] = ASCII_ZERO + {4'b0, digs[0]};
         end
      end else begin
         if (ctl_ff[5].oor) begin
            ch[0] = CHAR_STAR;
            ch[1] = CHAR_STAR;
            ch[2] = CHAR_STAR;
            ch[3] = CHAR_DOT;
            ch[4] = CHAR_STAR;
            ch[5] = CHAR_STAR;
         end else begin
            // leading zeros blanked, units digit always shown
            ch[0] = ctl_ff[5].big_tthou ? ASCII_ZERO + {4'b0, digs[4]} : CHAR_SPACE;
            ch[1] = ctl_ff[5].big_thou ? ASCII_ZERO + {4'b0, digs[3]} : CHAR_SPACE;
            ch[2] = ASCII_ZERO + {4'b0, digs[2]};
            ch[3] = CHAR_DOT;
            ch[4] = ASCII_ZERO + {4'b0, digs[1]};
            ch[5] = ASCII_ZERO + {4'b0, digs[0]};
         end
      end
      out_chars_in = {ch[5], ch[4], ch[3], ch[2], ch[1], ch[0]};
      out_oor_in = ctl_ff[5].oor;
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES - 1; k++) begin
         if (adv[k]) begin
            ctl_ff[k] <= ctl_in[k];
         end
      end
      if (adv[0]) s0_val_ff <= s0_val_in;
      if (adv[1]) s1_scaled_ff <= s1_scaled_in;
      if (adv[2]) s2_hund_ff <= s2_hund_in;
      if (adv[3]) begin
         s3_quo_ff <= s3_quo_in;
         s3_digs_ff <= s3_digs_in;
      end
      if (adv[4]) begin
         s4_quo_ff <= s4_quo_in;
         s4_digs_ff <= s4_digs_in;
      end
      if (adv[5]) begin
         s5_quo_ff <= s5_quo_in;
         s5_digs_ff <= s5_digs_in;
      end
      if (adv[6]) begin
         out_chars_ff <= out_chars_in;
         out_oor_ff <= out_oor_in;
      end
   end

   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata = out_chars_ff;
   assign rsp_tuser = out_oor_ff;

endmodule
`default_nettype wire

### rtl/fpaf_checker.sv
// port-level checks for the fixed-point ascii formatter, bound to the top level
`default_nettype none
module fpaf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   import fpaf_pkg::*;

   // a stalled item stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed under stall");

   // star pattern always puts a star in the second character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:8] == CHAR_STAR)
      else $error("out of range item without star pattern");

   // a shown number has its point in one of the two fixed places
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (rsp_tdata[23:16] == CHAR_DOT) || (rsp_tdata[31:24] == CHAR_DOT))
      else $error("decimal point missing");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp item valid after reset");

endmodule

bind fixed_point_ascii_formatter fpaf_checker u_fpaf_checker (.*);
`default_nettype wire
